>>> hdl/indexed_doubly_linked_list_defines.svh
// Assertion macros shared by the indexed doubly linked list RTL.
`ifndef INDEXED_DOUBLY_LINKED_LIST_DEFINES_SVH
`define INDEXED_DOUBLY_LINKED_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define IDLL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("idll assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define IDLL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("idll assertion failed");

`endif

>>> hdl/idll_pkg.sv
// Package with types, constants and reset-pattern functions for the linked list.
package idll_pkg;

  localparam int NODE_W    = 8;
  localparam int MAX_NODES = 255;
  // Highest node index that the reset chain reaches; indices are 8 bits.
  localparam logic [NODE_W-1:0] LAST_NODE =
    (MAX_NODES > 255) ? 8'd255 : NODE_W'(MAX_NODES);

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_UNLINK = 3'd1,
    OP_PUSH   = 3'd2,
    OP_POP    = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_SENTINEL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR1,
    S_WR2,
    S_DONE
  } state_t;

  // One write per table per cycle.
  typedef struct packed {
    logic  pwe;
    node_t paddr;
    node_t pdata;
    logic  nwe;
    node_t naddr;
    node_t ndata;
  } wr_t;

  function automatic node_t init_prev(input node_t i);
    node_t r;
    if (i == '0) begin
      r = LAST_NODE;
    end else if (i <= LAST_NODE) begin
      r = i - 8'd1;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic node_t init_next(input node_t i);
    node_t r;
    if (i == '0) begin
      r = (LAST_NODE != '0) ? 8'd1 : 8'd0;
    end else if (i < LAST_NODE) begin
      r = i + 8'd1;
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

>>> hdl/idll_tables.sv
// Predecessor and successor link tables with reset sweep and sentinel shadows.
module idll_tables
  import idll_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  rd_en,
  input  node_t rd_addr,
  input  wr_t   wr,
  output logic  busy,
  output node_t prev_rd,
  output node_t next_rd,
  output node_t head,
  output node_t tail
);

  node_t prev_mem [256];
  node_t next_mem [256];
  node_t clr_idx;
  wr_t   wr_eff;

  // While the sweep runs it owns both write ports.
  always_comb begin
    if (busy) begin
      wr_eff.pwe   = 1'b1;
      wr_eff.paddr = clr_idx;
      wr_eff.pdata = init_prev(clr_idx);
      wr_eff.nwe   = 1'b1;
      wr_eff.naddr = clr_idx;
      wr_eff.ndata = init_next(clr_idx);
    end else begin
      wr_eff = wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + 8'd1;
      if (clr_idx == 8'hFF) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_eff.pwe) begin
      prev_mem[wr_eff.paddr] <= wr_eff.pdata;
    end
    if (rd_en) begin
      prev_rd <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_eff.nwe) begin
      next_mem[wr_eff.naddr] <= wr_eff.ndata;
    end
    if (rd_en) begin
      next_rd <= next_mem[rd_addr];
    end
  end

  // Entry 0 of each table is mirrored so head and tail are always at hand.
  always_ff @(posedge clk) begin
    if (wr_eff.nwe && wr_eff.naddr == '0) begin
      head <= wr_eff.ndata;
    end
    if (wr_eff.pwe && wr_eff.paddr == '0) begin
      tail <= wr_eff.pdata;
    end
  end

endmodule

>>> hdl/indexed_doubly_linked_list.sv
// Indexed doubly linked list: two link tables, node 0 is the sentinel whose
// successor is the head and whose predecessor is the tail. A transaction
// occupies the block from acceptance until its result is loaded: the accepting
// cycle also reads both link tables at the node in question, states WR1 and
// WR2 write the links back (each table has one write port and an operation
// makes two writes to each), and state DONE loads the result register; the
// next transaction can be accepted in the cycle after that load. After reset
// a sweep writes the initial chain into all 256 entries of both tables; no
// transaction is taken until it ends. A finished result may wait in the output
// register while the next transaction is accepted; a second result that finds
// the register still occupied holds the block until the first one is taken.
`include "indexed_doubly_linked_list_defines.svh"

module indexed_doubly_linked_list
  import idll_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  node_a,
  input  logic [7:0]  node_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  node_out,
  output logic [7:0]  prev_of_node,
  output logic [7:0]  next_of_node,
  output logic [7:0]  head_node,
  output logic [7:0]  tail_node,
  output logic        is_empty
);

  state_t  state, state_next;
  logic    in_acc, out_load;
  logic    rd_en;
  wr_t     wr;
  logic    tbl_busy;
  node_t   prev_rd, next_rd, tbl_head, tbl_tail;

  // Decoded at acceptance.
  node_t   x_sel, nout_sel;
  status_t st_sel;
  logic    link_sel, unlink_sel;

  node_t   x, b, nout;
  status_t st;
  logic    do_link, do_unlink, do_read;

  idll_tables u_tables (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (x_sel),
    .wr      (wr),
    .busy    (tbl_busy),
    .prev_rd (prev_rd),
    .next_rd (next_rd),
    .head    (tbl_head),
    .tail    (tbl_tail)
  );

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    x_sel      = node_a;
    nout_sel   = '0;
    st_sel     = ST_DONE;
    link_sel   = 1'b0;
    unlink_sel = 1'b0;
    case (op_t'(op))
      OP_INSERT, OP_PUSH: begin
        x_sel = (op_t'(op) == OP_PUSH) ? tbl_tail : node_a;
        if (node_b == '0) begin
          st_sel = ST_SENTINEL;
        end else begin
          link_sel = 1'b1;
          nout_sel = node_b;
        end
      end
      OP_UNLINK: begin
        if (node_a == '0) begin
          st_sel = ST_SENTINEL;
        end else if (tbl_head == '0) begin
          st_sel = ST_EMPTY;
        end else begin
          unlink_sel = 1'b1;
          nout_sel   = node_a;
        end
      end
      OP_POP: begin
        x_sel = tbl_head;
        if (tbl_head == '0) begin
          st_sel = ST_EMPTY;
        end else begin
          unlink_sel = 1'b1;
          nout_sel   = tbl_head;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x    <= x_sel;
      b    <= node_b;
      nout <= nout_sel;
      st   <= st_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      do_link   <= 1'b0;
      do_unlink <= 1'b0;
      do_read   <= 1'b0;
    end else if (in_acc) begin
      do_link   <= link_sel;
      do_unlink <= unlink_sel;
      do_read   <= (op_t'(op) == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (!tbl_busy) state_next = S_IDLE;
      S_IDLE:  if (in_acc) state_next = S_WR1;
      S_WR1:   state_next = S_WR2;
      S_WR2:   state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Link writes follow the operation's order: for an insert the new node's
  // own links go first, then its neighbours; for an unlink the neighbours are
  // joined first, then the removed node is cleared.
  always_comb begin
    in_stall = (state != S_IDLE);
    rd_en    = in_acc;
    out_load = (state == S_DONE) && (!out_valid || !out_stall);
    wr       = '0;
    case (state)
      S_WR1: begin
        if (do_link) begin
          wr.pwe   = 1'b1;
          wr.paddr = b;
          wr.pdata = x;
          wr.nwe   = 1'b1;
          wr.naddr = b;
          wr.ndata = next_rd;
        end else if (do_unlink) begin
          wr.nwe   = 1'b1;
          wr.naddr = prev_rd;
          wr.ndata = next_rd;
          wr.pwe   = 1'b1;
          wr.paddr = next_rd;
          wr.pdata = prev_rd;
        end
      end
      S_WR2: begin
        if (do_link) begin
          wr.pwe   = 1'b1;
          wr.paddr = next_rd;
          wr.pdata = b;
          wr.nwe   = 1'b1;
          wr.naddr = x;
          wr.ndata = b;
        end else if (do_unlink) begin
          wr.pwe   = 1'b1;
          wr.paddr = x;
          wr.pdata = '0;
          wr.nwe   = 1'b1;
          wr.naddr = x;
          wr.ndata = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= st;
      node_out     <= nout;
      prev_of_node <= do_read ? prev_rd : '0;
      next_of_node <= do_read ? next_rd : '0;
      head_node    <= tbl_head;
      tail_node    <= (tbl_head == '0) ? '0 : tbl_tail;
      is_empty     <= (tbl_head == '0);
    end
  end

  `IDLL_ASSERT_IMP(a_no_write_idle, state == S_IDLE, !wr.pwe && !wr.nwe)
  `IDLL_ASSERT_IMP(a_fixed_latency, in_acc, ##3 (state == S_DONE))
  `IDLL_ASSERT_IMP(a_result_from_done, $rose(out_valid), $past(state) == S_DONE)
  `IDLL_ASSERT_IMP(a_empty_nulls, out_valid && is_empty, head_node == '0 && tail_node == '0)
  `IDLL_ASSERT_NXT(a_clear_holds_off, tbl_busy, in_stall)

endmodule
